>>> hdl/ctk_pkg.sv
// ----------------------------------------------------------------------------
// ctk_pkg
// Shared types, constants and helper functions for the calendar clock tick.
// ----------------------------------------------------------------------------
package ctk_pkg;

   // uptime counter width, fixed by the transaction format
   localparam int UPTIME_BITS  = 40;

   localparam int MS_PER_SEC   = 1000;
   localparam int MAX_SEC_STEP = 255;
   // elapsed ms at or above this always gives the clamped second step
   localparam int SAT_MS       = MAX_SEC_STEP * MS_PER_SEC;

   // residue folding for ms mod 125: 2^7 = 128 = 3 (mod 125)
   localparam int FOLD_CHUNK   = 7;
   localparam int FOLD_CHUNKS  = (UPTIME_BITS + FOLD_CHUNK - 1) / FOLD_CHUNK;
   localparam int FOLD_BITS    = FOLD_CHUNKS * FOLD_CHUNK;
   localparam int FOLD_W       = 18;
   localparam int FOLD_BASE    = 3;
   localparam int ODD_PART     = 125;
   // inverse of 125 modulo 256, used for the exact division by 1000
   localparam int INV125       = 213;
   localparam int ELAPSED_LO_W = 11;

   // year / 400 by reciprocal multiply, exact for 14-bit years
   localparam int YEAR_W       = 14;
   localparam int Y400_RECIP   = 20972;
   localparam int Y400_SHIFT   = 23;
   localparam int Y400_PROD_W  = 29;
   localparam int Y400_Q_W     = 6;

   // change mask bit positions
   localparam int CHG_SEC   = 0;
   localparam int CHG_MIN   = 1;
   localparam int CHG_HOUR  = 2;
   localparam int CHG_DAY   = 3;
   localparam int CHG_MONTH = 4;
   localparam int CHG_YEAR  = 5;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_LOAD = 1'b1
   } ctk_op_type;

   typedef struct packed {
      ctk_op_type             op;
      logic [UPTIME_BITS-1:0] uptime_ms;
      logic [13:0]            new_year;
      logic [3:0]             new_month;
      logic [4:0]             new_day;
      logic [4:0]             new_hour;
      logic [5:0]             new_minute;
      logic [5:0]             new_second;
      logic [2:0]             new_week;
   } ctk_req_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [5:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  week;
      logic [5:0]  change_mask;
      logic        day_rolled;
   } ctk_rsp_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  week;
   } ctk_load_type;

   typedef struct packed {
      ctk_op_type             op;
      ctk_load_type           load;
      logic [UPTIME_BITS-1:0] elapsed;
   } ctk_s1_type;

   typedef struct packed {
      ctk_op_type              op;
      ctk_load_type            load;
      logic [FOLD_W-1:0]       fold_sum;
      logic [ELAPSED_LO_W-1:0] elapsed_lo;
      logic                    sat;
      logic [Y400_Q_W-1:0]     year_q;
   } ctk_s2_type;

   typedef struct packed {
      ctk_op_type   op;
      ctk_load_type load;
      logic [8:0]   year_mod;
      logic [9:0]   rem_ms;
      logic [7:0]   secs;
      logic         sat;
   } ctk_s3_type;

   // weight of 7-bit chunk idx in the mod 125 fold: 3^idx mod 125
   function automatic logic [6:0] fold_weight(input int idx);
      int w;
      w = 1;
      for (int i = 0; i < idx; i++) begin
         w = (w * FOLD_BASE) % ODD_PART;
      end
      return 7'(w);
   endfunction

   // days in a month; anything outside 1..12 follows the february rule
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         default:                                    len = leap ? 5'd29 : 5'd28;
      endcase
      return len;
   endfunction

endpackage

>>> hdl/ctk_front.sv
// ----------------------------------------------------------------------------
// ctk_front
// Input register: captures a transaction and the ms elapsed since last tick.
// ----------------------------------------------------------------------------
module ctk_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ctk_pkg::ctk_req_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output ctk_pkg::ctk_s1_type  out_data
);

   logic                            valid_ff, valid_in;
   ctk_pkg::ctk_s1_type             data_ff, data_in;
   logic [ctk_pkg::UPTIME_BITS-1:0] last_ff, last_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.op         = in_data.op;
            data_in.load.year  = in_data.new_year;
            data_in.load.month = in_data.new_month;
            data_in.load.day   = in_data.new_day;
            data_in.load.hour  = in_data.new_hour;
            data_in.load.minute = in_data.new_minute;
            data_in.load.second = in_data.new_second;
            data_in.load.week  = in_data.new_week;
            // wraps modulo the counter width on a backward uptime
            data_in.elapsed    = in_data.uptime_ms - last_ff;
            if (in_data.op == ctk_pkg::OP_TICK) begin
               last_in = in_data.uptime_ms;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

>>> hdl/ctk_divide.sv
// ----------------------------------------------------------------------------
// ctk_divide
// Two stages splitting elapsed ms into whole seconds and a ms remainder,
// plus the year mod 400 used for the leap rule after a load.
// ----------------------------------------------------------------------------
module ctk_divide (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ctk_pkg::ctk_s1_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ctk_pkg::ctk_s3_type out_data
);

   logic                s2_valid_ff, s2_valid_in;
   ctk_pkg::ctk_s2_type s2_ff, s2_in;
   logic                s3_valid_ff, s3_valid_in;
   ctk_pkg::ctk_s3_type s3_ff, s3_in;
   logic                s2_ready;

   logic [ctk_pkg::FOLD_BITS-1:0]   padded;
   logic [ctk_pkg::FOLD_W-1:0]      fold_acc;
   logic [ctk_pkg::Y400_PROD_W-1:0] year_prod;

   logic [12:0] fold_t1;
   logic [8:0]  fold_t2;
   logic [6:0]  mod125;
   logic [2:0]  crt_k;
   logic [9:0]  rem;
   logic [10:0] whole_ms;

   assign s2_ready  = !s3_valid_ff || out_ready;
   assign in_ready  = !s2_valid_ff || s2_ready;
   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

   // stage 2: fold elapsed into a small residue sum, clamp check, year / 400
   always_comb begin
      padded   = ctk_pkg::FOLD_BITS'(in_data.elapsed);
      fold_acc = '0;
      for (int i = 0; i < ctk_pkg::FOLD_CHUNKS; i++) begin
         fold_acc = fold_acc
                  + ctk_pkg::FOLD_W'(padded[i*ctk_pkg::FOLD_CHUNK +: ctk_pkg::FOLD_CHUNK])
                  * ctk_pkg::FOLD_W'(ctk_pkg::fold_weight(i));
      end
      year_prod = ctk_pkg::Y400_PROD_W'(in_data.load.year)
                * ctk_pkg::Y400_PROD_W'(ctk_pkg::Y400_RECIP);

      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      if (in_ready) begin
         s2_valid_in       = in_valid;
         s2_in.op          = in_data.op;
         s2_in.load        = in_data.load;
         s2_in.fold_sum    = fold_acc;
         s2_in.elapsed_lo  = in_data.elapsed[ctk_pkg::ELAPSED_LO_W-1:0];
         s2_in.sat         = in_data.elapsed >= ctk_pkg::UPTIME_BITS'(ctk_pkg::SAT_MS);
         s2_in.year_q      = year_prod[ctk_pkg::Y400_SHIFT +: ctk_pkg::Y400_Q_W];
      end
   end

   // stage 3: finish mod 125, rebuild mod 1000, exact quotient mod 256
   always_comb begin
      fold_t1 = 13'(s2_ff.fold_sum[ctk_pkg::FOLD_W-1:7]) * 13'd3 + 13'(s2_ff.fold_sum[6:0]);
      fold_t2 = 9'(fold_t1[12:7]) * 9'd3 + 9'(fold_t1[6:0]);
      priority if (fold_t2 >= 9'd250) begin
         mod125 = 7'(fold_t2 - 9'd250);
      end else if (fold_t2 >= 9'd125) begin
         mod125 = 7'(fold_t2 - 9'd125);
      end else begin
         mod125 = 7'(fold_t2);
      end
      // pick the multiple of 125 that matches elapsed mod 8 (5 is its own inverse)
      crt_k    = 3'((s2_ff.elapsed_lo[2:0] - mod125[2:0]) * 3'd5);
      rem      = 10'(mod125) + 10'(crt_k) * 10'd125;
      whole_ms = s2_ff.elapsed_lo - 11'(rem);

      s3_valid_in = s3_valid_ff;
      s3_in       = s3_ff;
      if (s2_ready) begin
         s3_valid_in    = s2_valid_ff;
         s3_in.op       = s2_ff.op;
         s3_in.load     = s2_ff.load;
         s3_in.rem_ms   = rem;
         s3_in.secs     = 8'(whole_ms[10:3] * 8'(ctk_pkg::INV125));
         s3_in.sat      = s2_ff.sat;
         s3_in.year_mod = 9'(s2_ff.load.year
                         - ctk_pkg::YEAR_W'(s2_ff.year_q) * ctk_pkg::YEAR_W'(400));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

endmodule

>>> hdl/ctk_update.sv
// ----------------------------------------------------------------------------
// ctk_update
// Clock and calendar state with carry chain, and the result register.
// ----------------------------------------------------------------------------
module ctk_update (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ctk_pkg::ctk_s3_type  in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output ctk_pkg::ctk_rsp_type out_data
);

   logic [5:0]  second_ff, second_in;
   logic [5:0]  minute_ff, minute_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   logic [2:0]  week_ff, week_in;
   logic [8:0]  ymod_ff, ymod_in;
   logic [9:0]  subms_ff, subms_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   ctk_pkg::ctk_rsp_type rsp_ff, rsp_in;

   logic        fire;
   logic [10:0] sub_sum;
   logic        sub_carry;
   logic [8:0]  secs_c;
   logic [7:0]  step;
   logic [8:0]  s_sum;
   logic [2:0]  min_add;
   logic        min_carry, hour_carry, day_carry, month_carry, year_carry;
   logic [6:0]  mi_sum;
   logic [5:0]  h_sum;
   logic [6:0]  d_sum;
   logic [4:0]  mo_sum;
   logic [3:0]  w_sum;
   logic        leap;
   logic [5:0]  mask;

   assign in_ready  = !rsp_valid_ff || !out_stall;
   assign fire      = in_valid && in_ready;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      sub_sum   = 11'(subms_ff) + 11'(in_data.rem_ms);
      sub_carry = sub_sum >= 11'(ctk_pkg::MS_PER_SEC);
      secs_c    = 9'(in_data.secs) + 9'(sub_carry);
      if (in_data.sat || secs_c > 9'(ctk_pkg::MAX_SEC_STEP)) begin
         step = 8'(ctk_pkg::MAX_SEC_STEP);
      end else begin
         step = secs_c[7:0];
      end

      s_sum = 9'(second_ff) + 9'(step);
      priority if (s_sum >= 9'd300) begin
         min_add = 3'd5;
      end else if (s_sum >= 9'd240) begin
         min_add = 3'd4;
      end else if (s_sum >= 9'd180) begin
         min_add = 3'd3;
      end else if (s_sum >= 9'd120) begin
         min_add = 3'd2;
      end else if (s_sum >= 9'd60) begin
         min_add = 3'd1;
      end else begin
         min_add = 3'd0;
      end
      min_carry = min_add != 3'd0;

      mi_sum     = 7'(minute_ff) + 7'(min_add);
      hour_carry = min_carry && mi_sum > 7'd59;
      h_sum      = 6'(hour_ff) + 6'd1;
      day_carry  = hour_carry && h_sum > 6'd23;

      leap = (ymod_ff[1:0] == 2'd0) && (ymod_ff != 9'd100) && (ymod_ff != 9'd200)
          && (ymod_ff != 9'd300);
      d_sum       = 7'(day_ff) + 7'd1;
      month_carry = day_carry && d_sum > 7'(ctk_pkg::month_len(month_ff, leap));
      mo_sum      = 5'(month_ff) + 5'd1;
      year_carry  = month_carry && mo_sum > 5'd12;
      w_sum       = 4'(week_ff) + 4'd1;

      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      week_in   = week_ff;
      ymod_in   = ymod_ff;
      subms_in  = subms_ff;
      mask      = '0;

      if (in_data.op == ctk_pkg::OP_LOAD) begin
         second_in = in_data.load.second;
         minute_in = in_data.load.minute;
         hour_in   = in_data.load.hour;
         day_in    = 6'(in_data.load.day);
         month_in  = in_data.load.month;
         year_in   = in_data.load.year;
         week_in   = in_data.load.week;
         ymod_in   = in_data.year_mod;
      end else begin
         subms_in  = sub_carry ? 10'(sub_sum - 11'(ctk_pkg::MS_PER_SEC)) : 10'(sub_sum);
         second_in = 6'(s_sum - 9'(min_add) * 9'd60);
         mask[ctk_pkg::CHG_SEC] = 1'b1;
         if (min_carry) begin
            minute_in = hour_carry ? 6'(mi_sum - 7'd60) : 6'(mi_sum);
            mask[ctk_pkg::CHG_MIN] = 1'b1;
         end
         if (hour_carry) begin
            hour_in = day_carry ? 5'd0 : h_sum[4:0];
            mask[ctk_pkg::CHG_HOUR] = 1'b1;
         end
         if (day_carry) begin
            mask[ctk_pkg::CHG_DAY] = 1'b1;
            week_in = (w_sum > 4'd6) ? 3'd0 : w_sum[2:0];
            day_in  = month_carry ? 6'd1 : d_sum[5:0];
         end
         if (month_carry) begin
            mask[ctk_pkg::CHG_MONTH] = 1'b1;
            month_in = year_carry ? 4'd1 : mo_sum[3:0];
         end
         if (year_carry) begin
            mask[ctk_pkg::CHG_YEAR] = 1'b1;
            year_in = year_ff + 14'd1;
            // the 14-bit wrap lands on year 0, which is a multiple of 400
            if (year_ff == '1 || ymod_ff == 9'd399) begin
               ymod_in = 9'd0;
            end else begin
               ymod_in = ymod_ff + 9'd1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (in_ready) begin
         rsp_valid_in       = in_valid;
         rsp_in.year        = year_in;
         rsp_in.month       = month_in;
         rsp_in.day         = day_in;
         rsp_in.hour        = hour_in;
         rsp_in.minute      = minute_in;
         rsp_in.second      = second_in;
         rsp_in.week        = week_in;
         rsp_in.change_mask = mask;
         rsp_in.day_rolled  = mask[ctk_pkg::CHG_DAY];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= '0;
         minute_ff    <= '0;
         hour_ff      <= '0;
         day_ff       <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         week_ff      <= '0;
         ymod_ff      <= '0;
         subms_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            second_ff <= second_in;
            minute_ff <= minute_in;
            hour_ff   <= hour_in;
            day_ff    <= day_in;
            month_ff  <= month_in;
            year_ff   <= year_in;
            week_ff   <= week_in;
            ymod_ff   <= ymod_in;
            subms_ff  <= subms_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

>>> hdl/calendar_clock_tick.sv
// ----------------------------------------------------------------------------
// calendar_clock_tick - real-time calendar counter with gregorian rollover
// path: a transaction is registered in the front, fold, split and result registers
// throughput: one transaction per cycle when the result side does not stall, as the state update is combinational
// reset: synchronous, clears the date, time, last uptime and ms remainder
// ----------------------------------------------------------------------------
module calendar_clock_tick (
   input  logic                 clock,
   input  logic                 reset,
   // input transactions: uptime tick or date/time load
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ctk_pkg::ctk_req_type  req_data,
   // one result transaction per input transaction
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ctk_pkg::ctk_rsp_type rsp_data
);

   // pipeline: front register (elapsed ms) -> fold stage -> split stage
   //           -> calendar update and result register
   logic                front_valid, front_ready;
   ctk_pkg::ctk_s1_type front_data;
   logic                div_valid, div_ready;
   ctk_pkg::ctk_s3_type div_data;
   logic                upd_ready;

   // each stage takes a new transaction when empty or when its successor moves
   assign req_stall = !front_ready;

   // front: registers the transaction and the ms since the previous tick;
   // loads leave the remembered uptime alone
   ctk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_data  (front_data)
   );

   // divide: elapsed ms into whole seconds (mod 256, with a clamp flag) and a
   // ms remainder, without a divider; also year mod 400 for loaded years
   ctk_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_ready (upd_ready),
      .out_data  (div_data)
   );

   // update: remainder carry, second clamp, then second -> minute -> hour ->
   // day/weekday -> month -> year carries, all combinational for each transaction
   ctk_update u_update (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (upd_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // back pressure at the input only happens when the whole pipe is full
   // and the result is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && div_valid && front_valid))
      else $error("input stalled while the pipeline has room");

   // a day rollover always wraps the hour to zero and flags hour and day
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.day_rolled) |->
         (rsp_data.hour == 5'd0 && rsp_data.change_mask[ctk_pkg::CHG_HOUR]
          && rsp_data.change_mask[ctk_pkg::CHG_DAY]))
      else $error("day rollover without hour wrap");

   // a month carry restarts the day at 1 and only happens on a rollover
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.change_mask[ctk_pkg::CHG_MONTH]) |->
         (rsp_data.day == 6'd1 && rsp_data.day_rolled))
      else $error("month carry with bad day");
`endif

endmodule

>>> tb/sv/ctk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctk_checker
// Watches both channels of the calendar clock tick. Each accepted input
// transaction is run through a local calendar model and the predicted date is
// queued. Each accepted result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module ctk_checker
   import ctk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  ctk_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  ctk_rsp_type rsp_data,
   output int          mismatch_count,
   output int          results_owed
);

   // local copy of the calendar and uptime bookkeeping
   logic [5:0]  cal_sec = '0;
   logic [5:0]  cal_min = '0;
   logic [4:0]  cal_hour = '0;
   logic [5:0]  cal_day = '0;
   logic [3:0]  cal_month = '0;
   logic [13:0] cal_year = '0;
   logic [2:0]  cal_week = '0;
   logic [39:0] last_uptime_ms = '0;
   logic [9:0]  sub_ms = '0;

   ctk_rsp_type predicted_dates[$];
   int          result_index = 0;

   function automatic int unsigned days_in_month(input logic [3:0] m, input logic [13:0] y);
      logic leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
         4'd4, 4'd6, 4'd9, 4'd11: return 30;
         default: return leap ? 29 : 28;
      endcase
   endfunction

   // updates the calendar for one transaction and returns the date it reports
   function automatic ctk_rsp_type advance_calendar(input ctk_req_type t);
      ctk_rsp_type     r;
      logic [39:0]     elapsed;
      longint unsigned step_s;
      int unsigned     frac;
      int unsigned     s;
      int unsigned     mi;
      int unsigned     h;
      int unsigned     d;
      int unsigned     m;
      int unsigned     w;
      logic [5:0]      chg;
      logic            rolled;
      chg = '0;
      rolled = 1'b0;
      if (t.op == OP_LOAD) begin
         cal_year  = t.new_year;
         cal_month = t.new_month;
         cal_day   = {1'b0, t.new_day};
         cal_hour  = t.new_hour;
         cal_min   = t.new_minute;
         cal_sec   = t.new_second;
         cal_week  = t.new_week;
      end else begin
         elapsed = t.uptime_ms - last_uptime_ms;
         last_uptime_ms = t.uptime_ms;
         step_s = elapsed / 1000;
         frac = sub_ms + 32'(elapsed % 1000);
         if (frac >= 1000) begin
            frac = frac - 1000;
            step_s = step_s + 1;
         end
         sub_ms = 10'(frac);
         if (step_s > 255) step_s = 255;
         chg[CHG_SEC] = 1'b1;
         s = cal_sec + 32'(step_s);
         if (s > 59) begin
            mi = cal_min + s / 60;
            s = s % 60;
            chg[CHG_MIN] = 1'b1;
            if (mi > 59) begin
               h = cal_hour + mi / 60;
               mi = mi % 60;
               chg[CHG_HOUR] = 1'b1;
               if (h > 23) begin
                  h = 0;
                  rolled = 1'b1;
                  chg[CHG_DAY] = 1'b1;
                  d = cal_day + 1;
                  w = cal_week + 1;
                  cal_week = (w > 6) ? 3'd0 : 3'(w);
                  if (d > days_in_month(cal_month, cal_year)) begin
                     d = 1;
                     m = cal_month + 1;
                     chg[CHG_MONTH] = 1'b1;
                     if (m > 12) begin
                        m = 1;
                        cal_year = cal_year + 14'd1;
                        chg[CHG_YEAR] = 1'b1;
                     end
                     cal_month = 4'(m);
                  end
                  cal_day = 6'(d);
               end
               cal_hour = 5'(h);
            end
            cal_min = 6'(mi);
         end
         cal_sec = 6'(s);
      end
      r.year        = cal_year;
      r.month       = cal_month;
      r.day         = cal_day;
      r.hour        = cal_hour;
      r.minute      = cal_min;
      r.second      = cal_sec;
      r.week        = cal_week;
      r.change_mask = chg;
      r.day_rolled  = rolled;
      return r;
   endfunction

   task automatic check_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ctk_checker: result %0d %s: expected %0d, got %0d",
                     result_index, fname, want, got);
      end
   endtask

   always @(posedge clock) begin
      ctk_rsp_type want;
      if (reset) begin
         cal_sec = '0;
         cal_min = '0;
         cal_hour = '0;
         cal_day = '0;
         cal_month = '0;
         cal_year = '0;
         cal_week = '0;
         last_uptime_ms = '0;
         sub_ms = '0;
         predicted_dates.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_dates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ctk_checker: result %0d with no transaction pending: %p",
                           result_index, rsp_data);
            end else begin
               want = predicted_dates.pop_front();
               check_field("year", want.year, rsp_data.year);
               check_field("month", want.month, rsp_data.month);
               check_field("day", want.day, rsp_data.day);
               check_field("hour", want.hour, rsp_data.hour);
               check_field("minute", want.minute, rsp_data.minute);
               check_field("second", want.second, rsp_data.second);
               check_field("week", want.week, rsp_data.week);
               check_field("change_mask", want.change_mask, rsp_data.change_mask);
               check_field("day_rolled", want.day_rolled, rsp_data.day_rolled);
            end
            result_index++;
         end
         if (req_valid && !req_stall)
            predicted_dates.push_back(advance_calendar(req_data));
      end
      results_owed <= predicted_dates.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the calendar clock tick: directed rollovers (year,
// leap and century days, out-of-range loads, clamped and wrapped uptime), then
// random ticks and loads biased toward the end of a day, with random gaps on
// both channels and long result hold-offs. Checking lives in ctk_checker.
// ----------------------------------------------------------------------------
module tb;
   import ctk_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_CYCLES  = 150;
   localparam int SETTLE       = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ctk_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ctk_rsp_type rsp_data;

   int          mismatch_count;
   int          results_owed;

   // sender bookkeeping
   logic [39:0] uptime_now = '0;
   int          items_sent = 0;
   bit          send_quiet = 1'b0;
   int          cycle_count = 0;

   // receiver bookkeeping
   logic        rsp_hold = 1'b0;
   bit          rsp_quiet = 1'b0;
   int          rsp_gap = 0;
   int          rsp_taken = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   calendar_clock_tick u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ctk_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // random filler for every field, so unused fields toggle too
   function automatic ctk_req_type noise_item();
      logic [95:0] bits;
      ctk_req_type t;
      bits = {$urandom(), $urandom(), $urandom()};
      t = bits[$bits(ctk_req_type)-1:0];
      return t;
   endfunction

   function automatic ctk_req_type tick_item(input logic [39:0] up);
      ctk_req_type t;
      t = noise_item();
      t.op = OP_TICK;
      t.uptime_ms = up;
      return t;
   endfunction

   function automatic ctk_req_type load_item(input logic [13:0] y, input logic [3:0] mo,
                                             input logic [4:0] d, input logic [4:0] h,
                                             input logic [5:0] mi, input logic [5:0] s,
                                             input logic [2:0] w);
      ctk_req_type t;
      t = noise_item();
      t.op = OP_LOAD;
      t.new_year = y;
      t.new_month = mo;
      t.new_day = d;
      t.new_hour = h;
      t.new_minute = mi;
      t.new_second = s;
      t.new_week = w;
      return t;
   endfunction

   // years weighted toward the leap rule: plain, every 4th, centuries, every 400th
   function automatic logic [13:0] pick_year();
      case ($urandom_range(0, 3))
         0: return 14'($urandom());
         1: return 14'(4 * $urandom_range(0, 4095));
         2: return 14'(100 * $urandom_range(0, 163));
         default: return 14'(400 * $urandom_range(0, 40));
      endcase
   endfunction

   // offer one transaction, hold it until taken, then idle for a random gap
   task automatic push_item(input ctk_req_type item);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 10);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tick_after(input longint unsigned delta_ms);
      uptime_now = uptime_now + 40'(delta_ms);
      push_item(tick_item(uptime_now));
   endtask

   // stop offering and wait until every predicted result has come back;
   // the first edge lets the owed count catch up with the last transaction
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // result side: after each taken result, stall for a random number of cycles,
   // with occasional stretches of no stalls; rsp_hold forces a long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken++;
            if (rsp_taken % 40 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
            rsp_gap = rsp_quiet ? 0 : $urandom_range(0, 10);
         end else if (rsp_gap != 0) begin
            rsp_gap--;
         end
         rsp_stall <= rsp_hold || (rsp_gap != 0);
      end
   end

   // long hold-offs on the result side while the sender keeps offering, so the
   // pipeline fills up and has to push back on the input
   initial begin
      wait (items_sent >= 150);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
      wait (items_sent >= 650);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int          pick;
      ctk_req_type raw;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // from the reset state: zero elapsed, then a sub-second remainder, then a whole second
      push_item(tick_item(40'd0));
      uptime_now = 40'd999;
      push_item(tick_item(uptime_now));
      tick_after(1000);

      // new year's eve, every field carries, weekday wraps from saturday
      push_item(load_item(14'd2023, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd6));
      tick_after(1000);

      // leap year february, into the 29th and then into march
      push_item(load_item(14'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd58, 3'd3));
      tick_after(2000);
      push_item(load_item(14'd2024, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 3'd4));
      tick_after(1000);

      // century that is not a leap year, and one that is
      push_item(load_item(14'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd3));
      tick_after(1000);
      push_item(load_item(14'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 3'd1));
      tick_after(1000);

      // year counter wraps at its width
      push_item(load_item(14'h3fff, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd5));
      tick_after(1000);

      // all-zero load, then a jump to the top of the uptime range (clamped step)
      push_item(load_item('0, '0, '0, '0, '0, '0, '0));
      uptime_now = '1;
      push_item(tick_item(uptime_now));

      // uptime going backward wraps around
      uptime_now = 40'd5;
      push_item(tick_item(uptime_now));

      // every load field at its bit maximum, then the largest step
      push_item(load_item('1, '1, '1, '1, '1, '1, '1));
      tick_after(255000);

      // month past 12 uses the february length and wraps into the next year
      push_item(load_item(14'd2023, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59, 3'd7));
      tick_after(1000);

      // thirty-day month end
      push_item(load_item(14'd2023, 4'd4, 5'd30, 5'd23, 6'd59, 6'd59, 3'd2));
      tick_after(1000);

      // sender pause: let everything drain before the random part
      wait_drained();

      // ---- random part ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) wait_drained();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // load close to midnight near a month end; days 27..31 may exceed the month
            push_item(load_item(pick_year(), 4'($urandom_range(1, 12)),
                                5'($urandom_range(27, 31)), 5'($urandom_range(22, 23)),
                                6'($urandom_range(50, 59)), 6'($urandom_range(0, 59)),
                                3'($urandom_range(0, 6))));
         end else if (pick < 11) begin
            // load with arbitrary, possibly out-of-range fields
            raw = noise_item();
            raw.op = OP_LOAD;
            push_item(raw);
         end else if (pick < 45) begin
            tick_after($urandom_range(0, 1999));
         end else if (pick < 70) begin
            tick_after($urandom_range(1000, 60000));
         end else if (pick < 88) begin
            tick_after($urandom_range(60000, 300000));
         end else if (pick < 94) begin
            tick_after(1000 * $urandom_range(0, 300));
         end else begin
            // arbitrary uptime: huge forward or backward jumps
            uptime_now = 40'({$urandom(), $urandom()});
            push_item(tick_item(uptime_now));
         end
      end

      // ---- wind down ----
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
